// ----- rtl/core/dfl_pkg.sv -----
// ----------------------------------------------------------------------------
// dfl_pkg
// Shared types, transition table and token kinds of the first-token lexer.
// ----------------------------------------------------------------------------
package dfl_pkg;

   localparam int unsigned MAX_TOKEN_LEN_DEF = 255;
   localparam int unsigned STATE_W           = 4;
   localparam int unsigned CHAR_W            = 8;
   localparam int unsigned LEN_OUT_W         = 8;
   localparam int unsigned NUM_GROUPS        = 9;

   localparam logic [STATE_W-1:0] STATE_START = STATE_W'(1);
   localparam logic [STATE_W-1:0] STATE_STUCK = STATE_W'(0);

   typedef enum logic [3:0] {
      GRP_OTHER   = 4'd0,
      GRP_DASH    = 4'd1,
      GRP_DOT     = 4'd2,
      GRP_NEWLINE = 4'd3,
      GRP_BLANK   = 4'd4,
      GRP_F       = 4'd5,
      GRP_I       = 4'd6,
      GRP_LETTER  = 4'd7,
      GRP_DIGIT   = 4'd8
   } group_type;

   typedef enum logic [2:0] {
      KIND_ID      = 3'd0,
      KIND_IF      = 3'd1,
      KIND_ERROR   = 3'd2,
      KIND_REAL    = 3'd3,
      KIND_NUM     = 3'd4,
      KIND_COMMENT = 3'd5,
      KIND_WHITE   = 3'd6,
      KIND_NONE    = 3'd7
   } kind_type;

   localparam logic [7:0] CHR_DASH    = 8'h2D;
   localparam logic [7:0] CHR_DOT     = 8'h2E;
   localparam logic [7:0] CHR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHR_BLANK   = 8'h20;
   localparam logic [7:0] CHR_F       = 8'h66;
   localparam logic [7:0] CHR_I       = 8'h69;
   localparam logic [7:0] CHR_A_LO    = 8'h61;
   localparam logic [7:0] CHR_Z_LO    = 8'h7A;
   localparam logic [7:0] CHR_0       = 8'h30;
   localparam logic [7:0] CHR_9       = 8'h39;

   // rows: state, columns: other, '-', '.', newline, blank, 'f', 'i', letter, digit
   localparam logic [STATE_W-1:0] NEXT_TAB [16][NUM_GROUPS] = '{
      '{4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd13, 4'd9, 4'd5, 4'd0,  4'd12, 4'd4,  4'd2,  4'd4,  4'd7},
      '{4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd3,  4'd4,  4'd4,  4'd4},
      '{4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd4,  4'd4,  4'd4,  4'd4},
      '{4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd4,  4'd4,  4'd4,  4'd4},
      '{4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd6},
      '{4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd6},
      '{4'd0,  4'd0, 4'd8, 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd7},
      '{4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd8},
      '{4'd0,  4'd10,4'd0, 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd0,  4'd0, 4'd0, 4'd11, 4'd0,  4'd10, 4'd10, 4'd10, 4'd0},
      '{4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd0,  4'd0, 4'd0, 4'd0,  4'd12, 4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0}
   };

   localparam kind_type KIND_TAB [16] = '{
      KIND_NONE, KIND_NONE, KIND_ID,      KIND_IF,
      KIND_ID,   KIND_ERROR, KIND_REAL,   KIND_NUM,
      KIND_REAL, KIND_ERROR, KIND_NONE,   KIND_COMMENT,
      KIND_WHITE, KIND_ERROR, KIND_NONE,  KIND_NONE
   };

   typedef struct packed {
      logic                emit;
      kind_type            kind;
      logic [STATE_W-1:0]  state;
      logic                finished;
   } step_result_type;

endpackage

// ----- rtl/core/dfl_classify.sv -----
// ----------------------------------------------------------------------------
// dfl_classify
// Map one character byte, or a line-end beat, to its transition group.
// ----------------------------------------------------------------------------
module dfl_classify (
   input  logic [dfl_pkg::CHAR_W-1:0] char_code,
   input  logic                       line_end,
   output dfl_pkg::group_type         group
);

   always_comb begin
      if (line_end) begin
         group = dfl_pkg::GRP_OTHER;
      end else if (char_code == dfl_pkg::CHR_DASH) begin
         group = dfl_pkg::GRP_DASH;
      end else if (char_code == dfl_pkg::CHR_DOT) begin
         group = dfl_pkg::GRP_DOT;
      end else if (char_code == dfl_pkg::CHR_NEWLINE) begin
         group = dfl_pkg::GRP_NEWLINE;
      end else if (char_code == dfl_pkg::CHR_BLANK) begin
         group = dfl_pkg::GRP_BLANK;
      end else if (char_code == dfl_pkg::CHR_F) begin
         group = dfl_pkg::GRP_F;
      end else if (char_code == dfl_pkg::CHR_I) begin
         group = dfl_pkg::GRP_I;
      end else if (char_code inside {[dfl_pkg::CHR_A_LO:dfl_pkg::CHR_Z_LO]}) begin
         group = dfl_pkg::GRP_LETTER;
      end else if (char_code inside {[dfl_pkg::CHR_0:dfl_pkg::CHR_9]}) begin
         group = dfl_pkg::GRP_DIGIT;
      end else begin
         group = dfl_pkg::GRP_OTHER;
      end
   end

endmodule

// ----- rtl/core/dfl_step.sv -----
// ----------------------------------------------------------------------------
// dfl_step
// One lexer step: table lookup, token emit, length count and line reset.
// ----------------------------------------------------------------------------
module dfl_step #(
   parameter int unsigned MAX_TOKEN_LEN = dfl_pkg::MAX_TOKEN_LEN_DEF,
   parameter int unsigned LEN_W         = $clog2(MAX_TOKEN_LEN + 1)
) (
   input  logic [dfl_pkg::STATE_W-1:0]   state,
   input  logic [LEN_W-1:0]              len,
   input  logic                          finished,
   input  dfl_pkg::group_type            group,
   input  logic                          line_end,
   output dfl_pkg::step_result_type      result,
   output logic [LEN_W-1:0]              len_next,
   output logic [dfl_pkg::LEN_OUT_W-1:0] len_out
);

   logic [dfl_pkg::STATE_W-1:0] nx;
   dfl_pkg::kind_type           kind;
   logic [LEN_W+7:0]            len_wide;

   assign nx       = dfl_pkg::NEXT_TAB[state][group];
   assign kind     = dfl_pkg::KIND_TAB[state];
   assign len_wide = (LEN_W + 8)'(len);
   assign len_out  = (len_wide > (LEN_W + 8)'(255)) ? '1 : len_wide[7:0];

   always_comb begin
      result.emit     = 1'b0;
      result.kind     = kind;
      result.state    = state;
      result.finished = finished;
      len_next        = len;
      if (!finished) begin
         if (nx != dfl_pkg::STATE_STUCK) begin
            result.state = nx;
            if (len < LEN_W'(MAX_TOKEN_LEN)) begin
               len_next = len + LEN_W'(1);
            end
         end else if (kind != dfl_pkg::KIND_NONE) begin
            result.emit     = 1'b1;
            result.finished = 1'b1;
         end
      end
      if (line_end) begin
         result.state    = dfl_pkg::STATE_START;
         result.finished = 1'b0;
         len_next        = '0;
      end
   end

endmodule

// ----- rtl/core/dfa_first_token_lexer.sv -----
// ----------------------------------------------------------------------------
// dfa_first_token_lexer
// Table-driven lexer that reports kind and length of the first token of
// each line, one character beat per cycle while rsp is not stalled.
// ----------------------------------------------------------------------------
// channel | direction | tdata               | tuser           | tlast
// req     | in        | [7:0] char_code     | -               | line_end
// rsp     | out       | [7:0] token_length  | [2:0] token_kind| -
//
// One beat per cycle while rsp is not stalled: a beat lands in the input
// register, then one pass of class, table and length logic loads the result
// register once it is free or being taken. reset clears the lexer state to the
// start state and empties both registers. A stalled rsp holds the result; req
// keeps flowing while the result is taken.
// ----------------------------------------------------------------------------
module dfa_first_token_lexer #(
   parameter int unsigned MAX_TOKEN_LEN = dfl_pkg::MAX_TOKEN_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // line_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] token_length
   output logic [2:0] rsp_tuser    // [2:0] token_kind
);

   localparam int unsigned LEN_W = $clog2(MAX_TOKEN_LEN + 1);

   logic                            in_valid_ff, in_valid_in;
   logic [dfl_pkg::CHAR_W-1:0]      in_char_ff;
   logic                            in_end_ff;
   logic [dfl_pkg::STATE_W-1:0]     state_ff, state_in;
   logic [LEN_W-1:0]                len_ff, len_in;
   logic                            finished_ff, finished_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [2:0]                      rsp_kind_ff, rsp_kind_in;
   logic [dfl_pkg::LEN_OUT_W-1:0]   rsp_len_ff, rsp_len_in;

   logic                            advance;
   logic                            consume;
   logic                            req_accept;
   dfl_pkg::group_type              group;
   dfl_pkg::step_result_type        step;
   logic [LEN_W-1:0]                len_next;
   logic [dfl_pkg::LEN_OUT_W-1:0]   len_out;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign consume    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   dfl_classify u_classify (
      .char_code (in_char_ff),
      .line_end  (in_end_ff),
      .group     (group)
   );

   dfl_step #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
      .LEN_W         (LEN_W)
   ) u_step (
      .state    (state_ff),
      .len      (len_ff),
      .finished (finished_ff),
      .group    (group),
      .line_end (in_end_ff),
      .result   (step),
      .len_next (len_next),
      .len_out  (len_out)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      state_in     = state_ff;
      len_in       = len_ff;
      finished_in  = finished_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_len_in   = rsp_len_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (advance) begin
         rsp_valid_in = consume && step.emit;
      end
      if (consume) begin
         state_in    = step.state;
         len_in      = len_next;
         finished_in = step.finished;
         rsp_kind_in = step.kind;
         rsp_len_in  = len_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= dfl_pkg::STATE_START;
         len_ff       <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         len_ff       <= len_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_len_ff;
   assign rsp_tuser  = rsp_kind_ff;

   a_finished_silent: assert property (@(posedge clock) disable iff (reset)
      consume && finished_ff |=> !rsp_valid_ff)
      else $error("result after finished line");

   a_line_end_reset: assert property (@(posedge clock) disable iff (reset)
      consume && in_end_ff |=>
         state_ff == dfl_pkg::STATE_START && len_ff == '0 && !finished_ff)
      else $error("line end did not reset lexer state");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_TOKEN_LEN))
      else $error("token length above maximum");

   a_kind_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_kind_ff != dfl_pkg::KIND_NONE)
      else $error("result from non-final state");

endmodule

// ----- dv/dfa_first_token_lexer_tb.sv -----
// ----------------------------------------------------------------------------
// dfa_first_token_lexer_tb
// Self-checking bench for the first-token lexer. Character beats go in on req
// and token beats come out on rsp. A tracker class follows the lexer state per
// line and queues the token each line should report. A short directed part
// covers every token kind and the corner cases, then random lines follow.
// Each random line is mostly a well-formed token with a random terminator, and
// some lines are noise or lack a line end. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module dfa_first_token_lexer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TOKEN_LEN_CAP = 255;
   localparam int unsigned RANDOM_BEATS  = 1950;
   localparam logic [3:0]  LINE_START    = 4'd1;

   typedef enum int {
      CLS_OTHER, CLS_DASH, CLS_DOT, CLS_NEWLINE, CLS_BLANK,
      CLS_F, CLS_I, CLS_LETTER, CLS_DIGIT
   } char_class_type;

   typedef struct {
      dfl_pkg::kind_type kind;
      logic [7:0]        length;
   } token_type;

   // rows: state, columns: char_class_type
   localparam logic [3:0] LEX_NEXT [16][9] = '{
      '{4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0},
      '{4'd13, 4'd9,  4'd5, 4'd0,  4'd12, 4'd4, 4'd2,  4'd4,  4'd7},
      '{4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd3, 4'd4,  4'd4,  4'd4},
      '{4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd4, 4'd4,  4'd4,  4'd4},
      '{4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd4, 4'd4,  4'd4,  4'd4},
      '{4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd6},
      '{4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd6},
      '{4'd0,  4'd0,  4'd8, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd7},
      '{4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd8},
      '{4'd0,  4'd10, 4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0},
      '{4'd0,  4'd0,  4'd0, 4'd11, 4'd0,  4'd10, 4'd10, 4'd10, 4'd0},
      '{4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0},
      '{4'd0,  4'd0,  4'd0, 4'd0,  4'd12, 4'd0, 4'd0,  4'd0,  4'd0},
      '{4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0},
      '{4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0},
      '{4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0,  4'd0}
   };

   localparam dfl_pkg::kind_type LEX_KIND [16] = '{
      dfl_pkg::KIND_NONE,  dfl_pkg::KIND_NONE,  dfl_pkg::KIND_ID,
      dfl_pkg::KIND_IF,    dfl_pkg::KIND_ID,    dfl_pkg::KIND_ERROR,
      dfl_pkg::KIND_REAL,  dfl_pkg::KIND_NUM,   dfl_pkg::KIND_REAL,
      dfl_pkg::KIND_ERROR, dfl_pkg::KIND_NONE,  dfl_pkg::KIND_COMMENT,
      dfl_pkg::KIND_WHITE, dfl_pkg::KIND_ERROR, dfl_pkg::KIND_NONE,
      dfl_pkg::KIND_NONE
   };

   class first_token_tracker;
      logic [3:0]  lex_state = LINE_START;
      int unsigned token_len = 0;
      bit          line_done = 0;
      token_type   tokens_due[$];
      int          errors = 0;
      int          beats_taken = 0;

      function char_class_type class_of(logic [7:0] c, logic le);
         if (le) return CLS_OTHER;
         if (c == "-") return CLS_DASH;
         if (c == ".") return CLS_DOT;
         if (c == "\n") return CLS_NEWLINE;
         if (c == " ") return CLS_BLANK;
         if (c == "f") return CLS_F;
         if (c == "i") return CLS_I;
         if (c >= "a" && c <= "z") return CLS_LETTER;
         if (c >= "0" && c <= "9") return CLS_DIGIT;
         return CLS_OTHER;
      endfunction

      function void take_char(logic [7:0] c, logic le);
         logic [3:0] nxt;
         token_type  tok;
         beats_taken++;
         if (!line_done) begin
            nxt = LEX_NEXT[lex_state][class_of(c, le)];
            if (nxt != 4'd0) begin
               lex_state = nxt;
               if (token_len < TOKEN_LEN_CAP) token_len++;
            end else if (LEX_KIND[lex_state] != dfl_pkg::KIND_NONE) begin
               tok.kind   = LEX_KIND[lex_state];
               tok.length = (token_len > 255) ? 8'd255 : token_len[7:0];
               tokens_due.push_back(tok);
               line_done = 1;
            end
         end
         if (le) begin
            lex_state = LINE_START;
            token_len = 0;
            line_done = 0;
         end
      endfunction

      function void match_token(logic [2:0] kind, logic [7:0] length);
         token_type tok;
         if (tokens_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected token, expected none, actual kind %0d length %0d",
                     $time, kind, length);
            return;
         end
         tok = tokens_due.pop_front();
         if (kind !== tok.kind) begin
            errors++;
            $display("%0t: token kind mismatch, expected %0d, actual %0d",
                     $time, tok.kind, kind);
         end
         if (length !== tok.length) begin
            errors++;
            $display("%0t: token length mismatch, expected %0d, actual %0d",
                     $time, tok.length, length);
         end
      endfunction

      function int pending();
         return tokens_due.size();
      endfunction

      function void flag_leftovers();
         if (tokens_due.size() != 0) begin
            errors++;
            $display("%0t: %0d tokens never arrived, expected kind %0d length %0d first",
                     $time, tokens_due.size(), tokens_due[0].kind, tokens_due[0].length);
         end
      endfunction
   endclass

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] char_code
   logic       req_tlast  = 1'b0;    // line_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] token_length
   logic [2:0] rsp_tuser;            // [2:0] token_kind

   first_token_tracker tracker = new();

   bit quiet_stretch     = 0;
   int long_holds_asked  = 0;

   dfa_first_token_lexer #(
      .MAX_TOKEN_LEN(TOKEN_LEN_CAP)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("** dfa_first_token_lexer: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready === 1'b1) tracker.take_char(req_tdata, req_tlast);
         if (rsp_tvalid === 1'b1 && rsp_tready) tracker.match_token(rsp_tuser, rsp_tdata);
      end
   end

   function automatic int pick_idle();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic logic [7:0] digit_char();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] letter_char();
      return 8'("a" + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] alnum_char();
      if ($urandom_range(0, 35) < 26) return letter_char();
      return digit_char();
   endfunction

   function automatic logic [7:0] any_char();
      string punct;
      punct = "-. \nfi";
      case ($urandom_range(0, 3))
         0: return alnum_char();
         1: return punct[$urandom_range(0, 5)];
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // receiver: random stalls, plus long hold-offs on request
   initial begin : rsp_side
      int hold_left;
      int stall_left;
      int holds_done;
      hold_left  = 0;
      stall_left = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (holds_done != long_holds_asked) begin
            holds_done++;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet_stretch && $urandom_range(0, 99) < 25) begin
            stall_left = pick_idle() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_beat(input logic [7:0] c, input logic le);
      int gap;
      gap = (quiet_stretch || $urandom_range(0, 99) < 55) ? 0 : pick_idle();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= le;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic drain_tokens();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task automatic send_line(input int line_no);
      logic [7:0] body[$];
      int         n;
      int         pick;
      bit         long_line;
      long_line = (line_no % 97 == 5);
      n    = long_line ? $urandom_range(250, 300) : $urandom_range(1, 6);
      pick = long_line ? 3 * $urandom_range(0, 2) : $urandom_range(0, 11);
      case (pick)
         0, 1: begin
            case ($urandom_range(0, 2))
               0: body.push_back("i");
               1: body.push_back("f");
               default: body.push_back(letter_char());
            endcase
            repeat (n - 1) body.push_back(alnum_char());
         end
         2: begin
            body.push_back("i");
            body.push_back("f");
         end
         3: repeat (n) body.push_back(digit_char());
         4: begin
            repeat (n) body.push_back(digit_char());
            body.push_back(".");
            repeat ($urandom_range(0, 3)) body.push_back(digit_char());
         end
         5: begin
            body.push_back(".");
            repeat (n - 1) body.push_back(digit_char());
         end
         6: begin
            body.push_back("-");
            body.push_back("-");
            repeat (n - 1) body.push_back(letter_char());
            if ($urandom_range(0, 3) != 0) body.push_back("\n");
         end
         7: repeat (n) body.push_back(" ");
         8: begin
            case ($urandom_range(0, 2))
               0: body.push_back("-");
               1: body.push_back(".");
               default: body.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         default: repeat (n) body.push_back(any_char());
      endcase
      if ($urandom_range(0, 9) < 7) body.push_back(any_char());
      repeat ($urandom_range(0, 2)) body.push_back(any_char());
      foreach (body[i]) send_beat(body[i], 1'b0);
      if ($urandom_range(0, 9) != 0) send_end();
   endtask

   initial begin : req_side
      int line_no;
      int goal;
      int drain;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_text("if");     send_end();
      send_text("x-");     send_end();
      send_text(".5");     send_beat(8'h00, 1'b0); send_end();
      send_text("12");     send_end();
      send_text("--\n");   send_end();
      send_text(".");      send_beat(8'hFF, 1'b0); send_end();
      send_end();
      send_text("\n");     send_beat(8'h80, 1'b0); send_end();
      send_text("--");     send_end();
      send_text(" 7");     send_end();
      drain_tokens();

      goal    = tracker.beats_taken + RANDOM_BEATS;
      line_no = 0;
      while (tracker.beats_taken < goal) begin
         quiet_stretch = (line_no % 40) >= 34;
         if (line_no == 12 || line_no == 110) long_holds_asked++;
         if (line_no == 150) drain_tokens();
         send_line(line_no);
         line_no++;
      end

      req_tvalid <= 1'b0;
      drain = 0;
      do begin
         @(posedge clock);
         drain++;
      end while (tracker.pending() != 0 && drain < 5000);
      repeat (10) @(posedge clock);
      tracker.flag_leftovers();
      if (tracker.errors == 0) begin
         $display("** dfa_first_token_lexer: PASSED **");
      end else begin
         $display("** dfa_first_token_lexer: FAILED **");
      end
      $finish;
   end

endmodule

// ----- dfa_first_token_lexer.f -----
rtl/core/dfl_pkg.sv
rtl/core/dfl_classify.sv
rtl/core/dfl_step.sv
rtl/core/dfa_first_token_lexer.sv
dv/dfa_first_token_lexer_tb.sv
